@@ sv/ess_pkg.sv @@
// shared types and constants of the extent piece splitter
`timescale 1ns / 1ps

package ess_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int MIN_PIECE_SIZE_DEF = 4;
    localparam int FIELD_BITS         = 16;
    localparam int HALF_BITS          = FIELD_BITS - 1;
    localparam int AXES               = 3;
    localparam int CFG_IDX_BITS       = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_X_LO = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_X_HI = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_Y_LO = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_Y_HI = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_Z_LO = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_Z_HI = 3'd5;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_MUL,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

endpackage

@@ sv/ess_req_if.sv @@
// request channel: piece index and piece count
`timescale 1ns / 1ps

interface ess_req_if;
    import ess_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] piece_index;
    logic [FIELD_BITS-1:0] piece_count;

    modport source (output valid, output piece_index, output piece_count, input ready);
    modport sink   (input valid, input piece_index, input piece_count, output ready);
endinterface

@@ sv/ess_rsp_if.sv @@
// result channel: piece extent and nonempty flag
`timescale 1ns / 1ps

interface ess_rsp_if #(
    parameter int COORD_BITS = ess_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] piece_x_lo;
    logic signed [COORD_BITS-1:0] piece_x_hi;
    logic signed [COORD_BITS-1:0] piece_y_lo;
    logic signed [COORD_BITS-1:0] piece_y_hi;
    logic signed [COORD_BITS-1:0] piece_z_lo;
    logic signed [COORD_BITS-1:0] piece_z_hi;
    logic                         piece_nonempty;

    modport source (
        output valid, output piece_x_lo, output piece_x_hi, output piece_y_lo,
        output piece_y_hi, output piece_z_lo, output piece_z_hi, output piece_nonempty,
        input ready
    );
    modport sink (
        input valid, input piece_x_lo, input piece_x_hi, input piece_y_lo,
        input piece_y_hi, input piece_z_lo, input piece_z_hi, input piece_nonempty,
        output ready
    );
endinterface

@@ sv/ess_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ess_div #(
    parameter int NUM_BITS = 31,
    parameter int DEN_BITS = 16,
    parameter int Q_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [Q_BITS-1:0]   o_quot
);
    localparam int CNT_BITS = (Q_BITS > 1) ? $clog2(Q_BITS) : 1;

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [Q_BITS-1:0]   r_q;

    logic [DEN_BITS:0] w_trial;
    logic [DEN_BITS:0] w_diff;
    logic              w_ge;

    always_comb begin
        w_trial = {r_rem, r_q[Q_BITS-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(Q_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_BITS'(i_num[NUM_BITS-1:Q_BITS]);
            r_q   <= i_num[Q_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
            r_q   <= {r_q[Q_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a run");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_den)
        else $error("partial remainder not below divisor");
endmodule

@@ sv/extent_piece_splitter.sv @@
// top level: extent piece splitter by recursive bisection
//
// i_req carries piece_index and piece_count; o_rsp returns the extent of that
// piece and a nonempty flag, one result per request. The whole extent sits in
// six registers written through i_cfg_we / i_cfg_idx / i_cfg_data (indices
// x_lo, x_hi, y_lo, y_hi, z_lo, z_hi; others ignored); the user must write them
// only while idle, which the block itself does not enforce. One item runs up
// to 16 bisection rounds. A round runs axis choice, one multiply, COORD_BITS
// steps of the shared restoring divider and the extent update.
// i_req.ready is high only while no item is in work; the result sits in an
// output register, so the next item is taken while it waits. If the output
// register is still full when an item finishes, the block holds until it is
// taken. Reset clears the extent registers to zero and empties the output.
`timescale 1ns / 1ps

module extent_piece_splitter #(
    parameter int COORD_BITS     = ess_pkg::COORD_BITS_DEF,
    parameter int MIN_PIECE_SIZE = ess_pkg::MIN_PIECE_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ess_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0]             i_cfg_data,
    ess_req_if.sink                           i_req,
    ess_rsp_if.source                         o_rsp
);
    import ess_pkg::*;

    localparam int SZ_BITS   = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
    localparam int PROD_BITS = COORD_BITS + HALF_BITS;
    localparam logic signed [SZ_BITS-1:0] MIN2 = SZ_BITS'(2 * MIN_PIECE_SIZE);

    t_state r_state;
    t_state n_state;

    logic signed [COORD_BITS-1:0] r_whole_lo [AXES];
    logic signed [COORD_BITS-1:0] r_whole_hi [AXES];
    logic signed [COORD_BITS-1:0] r_lo       [AXES];
    logic signed [COORD_BITS-1:0] r_hi       [AXES];
    logic signed [COORD_BITS-1:0] r_out_lo   [AXES];
    logic signed [COORD_BITS-1:0] r_out_hi   [AXES];
    logic                         r_out_nonempty;
    logic                         r_out_valid;
    logic                         r_nonempty;
    logic [FIELD_BITS-1:0]        r_piece;
    logic [FIELD_BITS-1:0]        r_count;
    logic [HALF_BITS-1:0]         r_half;
    logic [COORD_BITS-1:0]        r_size;
    t_axis                        r_axis;

    logic signed [SZ_BITS-1:0] w_size [AXES];
    logic                      w_split;
    t_axis                     w_axis;
    logic [COORD_BITS-1:0]     w_sel_size;
    logic [PROD_BITS-1:0]      w_prod;
    logic [COORD_BITS-1:0]     w_quot;
    logic [COORD_BITS-1:0]     w_mid;
    logic                      w_first;
    logic                      w_div_done;
    logic                      w_div_start;
    logic                      w_out_free;
    logic                      w_load_out;
    logic                      w_req_ready;

    // per-axis sizes and axis choice, z first, then y, then x
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_size[a] = SZ_BITS'($signed(r_hi[a])) - SZ_BITS'($signed(r_lo[a]));
        end
        w_split    = 1'b1;
        w_axis     = AX_X;
        w_sel_size = w_size[AX_X][COORD_BITS-1:0];
        priority if (w_size[AX_Z] >= w_size[AX_Y] && w_size[AX_Z] >= w_size[AX_X]
                     && w_size[AX_Z] >= MIN2) begin
            w_axis     = AX_Z;
            w_sel_size = w_size[AX_Z][COORD_BITS-1:0];
        end else if (w_size[AX_Y] >= w_size[AX_X] && w_size[AX_Y] >= MIN2) begin
            w_axis     = AX_Y;
            w_sel_size = w_size[AX_Y][COORD_BITS-1:0];
        end else if (w_size[AX_X] >= MIN2) begin
            w_axis     = AX_X;
            w_sel_size = w_size[AX_X][COORD_BITS-1:0];
        end else begin
            w_split = 1'b0;
        end
    end

    assign w_prod     = PROD_BITS'(r_size) * PROD_BITS'(r_half);
    assign w_mid      = r_lo[r_axis] + w_quot;
    assign w_first    = r_piece < {1'b0, r_half};
    assign w_out_free = !r_out_valid || o_rsp.ready;

    ess_div #(
        .NUM_BITS (PROD_BITS),
        .DEN_BITS (FIELD_BITS),
        .Q_BITS   (COORD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_SEL;
            S_SEL: begin
                if (r_count > FIELD_BITS'(1) && w_split) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: if (w_div_done) n_state = S_UPD;
            S_UPD: n_state = S_SEL;
            S_OUT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_req_ready = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: w_req_ready = 1'b1;
            S_MUL:  w_div_start = 1'b1;
            S_OUT:  w_load_out  = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_whole_lo[a] <= '0;
                r_whole_hi[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WHOLE_X_LO: r_whole_lo[AX_X] <= i_cfg_data;
                    REG_WHOLE_X_HI: r_whole_hi[AX_X] <= i_cfg_data;
                    REG_WHOLE_Y_LO: r_whole_lo[AX_Y] <= i_cfg_data;
                    REG_WHOLE_Y_HI: r_whole_hi[AX_Y] <= i_cfg_data;
                    REG_WHOLE_Z_LO: r_whole_lo[AX_Z] <= i_cfg_data;
                    REG_WHOLE_Z_HI: r_whole_hi[AX_Z] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // working extent and round bookkeeping
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    for (int a = 0; a < AXES; a++) begin
                        r_lo[a] <= r_whole_lo[a];
                        r_hi[a] <= r_whole_hi[a];
                    end
                    r_piece    <= i_req.piece_index;
                    r_count    <= i_req.piece_count;
                    r_nonempty <= 1'b1;
                end
            end
            S_SEL: begin
                if (r_count > FIELD_BITS'(1)) begin
                    if (w_split) begin
                        r_axis <= w_axis;
                        r_size <= w_sel_size;
                        r_half <= r_count[FIELD_BITS-1:1];
                    end else if (r_piece != '0) begin
                        r_nonempty <= 1'b0;
                    end
                end
            end
            S_UPD: begin
                if (w_first) begin
                    r_hi[r_axis] <= w_mid;
                    r_count      <= FIELD_BITS'(r_half);
                end else begin
                    r_lo[r_axis] <= w_mid;
                    r_count      <= r_count - FIELD_BITS'(r_half);
                    r_piece      <= r_piece - FIELD_BITS'(r_half);
                end
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            for (int a = 0; a < AXES; a++) begin
                r_out_lo[a] <= r_lo[a];
                r_out_hi[a] <= r_hi[a];
            end
            r_out_nonempty <= r_nonempty;
        end
    end

    assign i_req.ready          = w_req_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.piece_x_lo     = r_out_lo[AX_X];
    assign o_rsp.piece_x_hi     = r_out_hi[AX_X];
    assign o_rsp.piece_y_lo     = r_out_lo[AX_Y];
    assign o_rsp.piece_y_hi     = r_out_hi[AX_Y];
    assign o_rsp.piece_z_lo     = r_out_lo[AX_Z];
    assign o_rsp.piece_z_hi     = r_out_hi[AX_Z];
    assign o_rsp.piece_nonempty = r_out_nonempty;

    a_cut_size_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> SZ_BITS'(r_size) >= MIN2 && r_count > FIELD_BITS'(1))
        else $error("cut started on an axis below the minimum size");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |-> !w_load_out)
        else $error("output register overwritten while held");
endmodule

@@ test/extent_piece_splitter_tb.sv @@
// self-checking testbench for the extent piece splitter
`timescale 1ns / 1ps

module extent_piece_splitter_tb;
    import ess_pkg::*;

    localparam int COORD_BITS        = COORD_BITS_DEF;
    localparam int MIN_PIECE         = MIN_PIECE_SIZE_DEF;
    localparam int RESET_CYCLES      = 7;
    localparam int SETTLE_CYCLES     = 4;
    localparam int TAIL_CYCLES       = 330;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int REPORT_LIMIT      = 10;
    localparam int RANDOM_PHASES     = 20;
    localparam int QUERIES_PER_PHASE = 56;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x_lo;
        coord_t x_hi;
        coord_t y_lo;
        coord_t y_hi;
        coord_t z_lo;
        coord_t z_hi;
        logic   nonempty;
    } piece_ext_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG
    } stall_mode_t;

    localparam logic [CFG_IDX_BITS-1:0] EXTENT_REGS [6] = '{
        REG_WHOLE_X_LO, REG_WHOLE_X_HI, REG_WHOLE_Y_LO,
        REG_WHOLE_Y_HI, REG_WHOLE_Z_LO, REG_WHOLE_Z_HI
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [COORD_BITS-1:0]   cfg_data;

    ess_req_if                          req_ch ();
    ess_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_ch ();

    extent_piece_splitter #(
        .COORD_BITS     (COORD_BITS),
        .MIN_PIECE_SIZE (MIN_PIECE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    coord_t      whole_ext [6];
    piece_ext_t  pieces_expected [$];
    stall_mode_t rsp_stall_mode = STALL_NONE;
    bit          sender_gaps_on = 1'b0;
    int          burst_left     = 0;
    int          stall_left     = 0;
    int          quiet_cycles   = 0;
    int          mismatches     = 0;
    int          queries_sent   = 0;
    int          results_seen   = 0;
    int          empty_seen     = 0;
    int          wide_counts    = 0;
    int          extent_loads   = 0;

    always #6 i_clk = ~i_clk;

    // bisect the whole extent until the asked piece is left
    function automatic piece_ext_t split_extent(input logic [FIELD_BITS-1:0] idx,
                                                input logic [FIELD_BITS-1:0] cnt);
        longint     bound [6];
        longint     span [AXES];
        longint     piece;
        longint     count;
        longint     half;
        longint     mid;
        t_axis      cut_axis;
        bit         can_cut;
        bit         nonempty;
        piece_ext_t res;
        for (int r = 0; r < 6; r++)
            bound[r] = longint'(whole_ext[r]);
        piece    = longint'(idx);
        count    = longint'(cnt);
        nonempty = 1'b1;
        cut_axis = AX_X;
        while (count > 1) begin
            span[AX_X] = bound[REG_WHOLE_X_HI] - bound[REG_WHOLE_X_LO];
            span[AX_Y] = bound[REG_WHOLE_Y_HI] - bound[REG_WHOLE_Y_LO];
            span[AX_Z] = bound[REG_WHOLE_Z_HI] - bound[REG_WHOLE_Z_LO];
            can_cut = 1'b1;
            if (span[AX_Z] >= span[AX_Y] && span[AX_Z] >= span[AX_X] &&
                span[AX_Z] / 2 >= MIN_PIECE) begin
                cut_axis = AX_Z;
            end else if (span[AX_Y] >= span[AX_X] && span[AX_Y] / 2 >= MIN_PIECE) begin
                cut_axis = AX_Y;
            end else if (span[AX_X] / 2 >= MIN_PIECE) begin
                cut_axis = AX_X;
            end else begin
                can_cut = 1'b0;
            end
            if (!can_cut) begin
                if (piece == 0) begin
                    count = 1;
                end else begin
                    nonempty = 1'b0;
                    break;
                end
            end else begin
                half = count / 2;
                mid  = bound[2 * int'(cut_axis)] + (span[cut_axis] * half) / count;
                if (piece < half) begin
                    bound[2 * int'(cut_axis) + 1] = mid;
                    count = half;
                end else begin
                    bound[2 * int'(cut_axis)] = mid;
                    count = count - half;
                    piece = piece - half;
                end
            end
        end
        res.x_lo     = coord_t'(bound[REG_WHOLE_X_LO]);
        res.x_hi     = coord_t'(bound[REG_WHOLE_X_HI]);
        res.y_lo     = coord_t'(bound[REG_WHOLE_Y_LO]);
        res.y_hi     = coord_t'(bound[REG_WHOLE_Y_HI]);
        res.z_lo     = coord_t'(bound[REG_WHOLE_Z_LO]);
        res.z_hi     = coord_t'(bound[REG_WHOLE_Z_HI]);
        res.nonempty = nonempty;
        return res;
    endfunction

    function automatic string fmt_piece(input piece_ext_t p);
        return $sformatf("x %0d..%0d y %0d..%0d z %0d..%0d nonempty %0b",
                         p.x_lo, p.x_hi, p.y_lo, p.y_hi, p.z_lo, p.z_hi, p.nonempty);
    endfunction

    function automatic void pick_axis_bounds(output coord_t lo, output coord_t hi);
        int mode;
        int a;
        int b;
        mode = $urandom_range(0, 9);
        a    = int'($urandom_range(0, 65535)) - 32768;
        if (mode < 3)
            b = a + int'($urandom_range(0, 12));
        else if (mode < 6)
            b = a + int'($urandom_range(13, 3000));
        else if (mode < 8)
            b = int'($urandom_range(0, 65535)) - 32768;
        else if (mode == 8)
            b = a - int'($urandom_range(1, 500));
        else
            b = a;
        if (b > 32767)
            b = 32767;
        if (b < -32768)
            b = -32768;
        lo = coord_t'(a);
        hi = coord_t'(b);
    endfunction

    task automatic load_whole_extent(input coord_t xl, input coord_t xh, input coord_t yl,
                                     input coord_t yh, input coord_t zl, input coord_t zh);
        coord_t vals [6];
        vals = '{xl, xh, yl, yh, zl, zh};
        for (int r = 0; r < 6; r++) begin
            @(negedge i_clk);
            cfg_we   = 1'b1;
            cfg_idx  = EXTENT_REGS[r];
            cfg_data = vals[r];
            whole_ext[EXTENT_REGS[r]] = vals[r];
        end
        @(negedge i_clk);
        cfg_we = 1'b0;
        extent_loads++;
    endtask

    task automatic send_query(input logic [FIELD_BITS-1:0] idx,
                              input logic [FIELD_BITS-1:0] cnt);
        int gap;
        @(negedge i_clk);
        if (sender_gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 24);
            burst_left = $urandom_range(1, 12);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        req_ch.valid       = 1'b1;
        req_ch.piece_index = idx;
        req_ch.piece_count = cnt;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        pieces_expected.push_back(split_extent(idx, cnt));
        queries_sent++;
        if (cnt > 1024)
            wide_counts++;
    endtask

    task automatic send_random_query();
        int                    r;
        logic [FIELD_BITS-1:0] cnt;
        logic [FIELD_BITS-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 55)
            cnt = FIELD_BITS'($urandom_range(0, 16));
        else if (r < 80)
            cnt = FIELD_BITS'($urandom_range(17, 1024));
        else
            cnt = FIELD_BITS'($urandom_range(0, 65535));
        if (r >= 92 || cnt == 0 || $urandom_range(0, 9) == 0)
            idx = FIELD_BITS'($urandom_range(0, 65535));
        else
            idx = FIELD_BITS'($urandom_range(0, cnt - 1));
        send_query(idx, cnt);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pieces_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_extent();
        rsp_stall_mode = STALL_NONE;
        sender_gaps_on = 1'b0;
        send_query(0, 0);
        send_query(0, 1);
        send_query(0, 2);
        send_query(1, 2);
        wait_all_results();
    endtask

    task automatic test_full_range();
        load_whole_extent(-32768, 32767, -32768, 32767, -32768, 32767);
        rsp_stall_mode = STALL_RANDOM;
        send_query(0, 2);
        send_query(1, 2);
        send_query(0, 65535);
        send_query(65535, 65535);
        // index past the count ends in the last piece
        send_query(65535, 3);
        send_query(12345, 0);
        send_query(7, 1);
        send_query(0, 3);
        send_query(2, 3);
        wait_all_results();
    endtask

    task automatic test_axis_preference();
        rsp_stall_mode = STALL_LONG;
        sender_gaps_on = 1'b1;
        load_whole_extent(0, 100, 0, 100, 0, 100);
        send_query(0, 2);
        send_query(1, 2);
        wait_all_results();
        load_whole_extent(0, 100, -50, 50, 0, 20);
        send_query(1, 4);
        wait_all_results();
        load_whole_extent(-5, 95, 0, 10, 3, 3);
        send_query(2, 3);
        wait_all_results();
    endtask

    task automatic test_no_split_and_reversed();
        load_whole_extent(100, -100, 50, -50, 0, 7);
        send_query(0, 4);
        send_query(2, 4);
        send_query(9, 4);
        wait_all_results();
        // minimum cuttable size on x only
        load_whole_extent(0, 8, 0, 7, 0, 7);
        send_query(1, 2);
        send_query(2, 3);
        wait_all_results();
    endtask

    task automatic test_pressure_pause();
        load_whole_extent(0, 2000, -1000, 1000, -300, 300);
        rsp_stall_mode = STALL_LONG;
        sender_gaps_on = 1'b0;
        repeat (3) begin
            repeat (8) send_random_query();
            wait_all_results();
        end
    endtask

    task automatic test_random_phases();
        coord_t xl, xh, yl, yh, zl, zh;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    xl = -32768; xh = 32767; yl = -32768; yh = 32767; zl = -32768; zh = 32767;
                end
                1: begin
                    xl = 0; xh = 0; yl = 0; yh = 0; zl = 0; zh = 0;
                end
                2: begin
                    xl = 32767; xh = -32768; yl = 32767; yh = -32768; zl = 32767; zh = -32768;
                end
                3: begin
                    xl = -4; xh = 4; yl = 32759; yh = 32767; zl = -32768; zh = -32760;
                end
                default: begin
                    pick_axis_bounds(xl, xh);
                    pick_axis_bounds(yl, yh);
                    pick_axis_bounds(zl, zh);
                end
            endcase
            load_whole_extent(xl, xh, yl, yh, zl, zh);
            if (ph % 4 == 0) begin
                rsp_stall_mode = STALL_NONE;
                sender_gaps_on = 1'b0;
            end else begin
                rsp_stall_mode = stall_mode_t'($urandom_range(0, 2));
                sender_gaps_on = 1'($urandom_range(0, 1));
            end
            repeat (QUERIES_PER_PHASE) send_random_query();
            wait_all_results();
        end
    endtask

    // result side: stall pattern driven on the falling edge
    always @(negedge i_clk) begin
        case (rsp_stall_mode)
            STALL_NONE: begin
                rsp_ch.ready = 1'b1;
            end
            STALL_RANDOM: begin
                rsp_ch.ready = 1'($urandom_range(0, 1));
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    rsp_ch.ready = 1'b0;
                end else if ($urandom_range(0, 5) == 0) begin
                    stall_left   = $urandom_range(1, 40);
                    rsp_ch.ready = 1'b0;
                end else begin
                    rsp_ch.ready = 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin : check_result
        piece_ext_t got;
        piece_ext_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.x_lo     = rsp_ch.piece_x_lo;
            got.x_hi     = rsp_ch.piece_x_hi;
            got.y_lo     = rsp_ch.piece_y_lo;
            got.y_hi     = rsp_ch.piece_y_hi;
            got.z_lo     = rsp_ch.piece_z_lo;
            got.z_hi     = rsp_ch.piece_z_hi;
            got.nonempty = rsp_ch.piece_nonempty;
            results_seen++;
            if (got.nonempty === 1'b0)
                empty_seen++;
            if (pieces_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected piece: %s", fmt_piece(got));
            end else begin
                want = pieces_expected.pop_front();
                if (got.x_lo !== want.x_lo || got.x_hi !== want.x_hi ||
                    got.y_lo !== want.y_lo || got.y_hi !== want.y_hi ||
                    got.z_lo !== want.z_lo || got.z_hi !== want.z_hi ||
                    got.nonempty !== want.nonempty) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("piece mismatch: expected %s, got %s",
                                 fmt_piece(want), fmt_piece(got));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_WHOLE_X_LO;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.piece_index = '0;
        req_ch.piece_count = '0;
        rsp_ch.ready       = 1'b0;
        for (int r = 0; r < 6; r++)
            whole_ext[r] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_extent();
        test_full_range();
        test_axis_preference();
        test_no_split_and_reversed();
        test_pressure_pause();
        test_random_phases();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pieces_expected.size() != 0) begin
            $display("%0d pieces never returned", pieces_expected.size());
            mismatches += pieces_expected.size();
        end
        $display("%0d queries over %0d whole extents, %0d results checked, %0d mismatches",
                 queries_sent, extent_loads, results_seen, mismatches);
        $display("%0d empty pieces returned, %0d queries with over 1024 pieces",
                 empty_seen, wide_counts);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ess_pkg.sv
sv/ess_req_if.sv
sv/ess_rsp_if.sv
sv/ess_div.sv
sv/extent_piece_splitter.sv
test/extent_piece_splitter_tb.sv
